// File: hw/rtl/iba_pkg.sv
// Package: shared types and constants for the indexed block allocator.
package iba_pkg;
    localparam int NumBlocks  = 64;
    localparam int NumFileIds = 64;
    localparam int PosW       = $clog2(NumBlocks);
    localparam int FidW       = $clog2(NumFileIds);
    localparam int CntW       = PosW + 1;
    localparam int ListAw     = FidW + 6;
    localparam int ClrW       = (PosW > FidW) ? PosW : FidW;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SEEK = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_NO_FILE  = 3'd2;
    localparam logic [2:0] ST_NO_BLOCK = 3'd3;
    localparam logic [2:0] ST_EXISTS   = 3'd4;

    localparam logic [0:0] REG_SEED = 1'd0;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] file_id;
        logic [6:0] size_blocks;
        logic [5:0] block_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] block_pos;
        logic [0:0] block_kind;
        logic [0:0] last;
        logic [6:0] free_blocks;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_META, S_DECIDE, S_SCAN, S_SCAN_CHK, S_SEEK_RD, S_SEEK_OUT,
        S_DEL_RD, S_DEL_FREE, S_DEL_IDX, S_EMIT, S_CLEAR, S_SCAN_TST
    } t_state;

    function automatic logic [5:0] lfsr_next(input logic [5:0] v);
        lfsr_next = {v[4:0], v[5] ^ v[4]};
    endfunction
endpackage

// File: hw/rtl/iba_ram.sv
// Generic synchronous RAM, one write port, one registered read port.
module iba_ram #(
    parameter int Aw = 6,
    parameter int Dw = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [Aw-1:0] i_waddr,
    input  logic [Dw-1:0] i_wdata,
    input  logic [Aw-1:0] i_raddr,
    output logic [Dw-1:0] o_rdata
);
    logic [Dw-1:0] mem [2**Aw];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: hw/rtl/indexed_block_allocator.sv
// Top level: indexed block allocator with occupancy bitmap and file tables.
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_ready  | i_word (t_in_word)
//  out     | out | o_valid / i_ready  | o_word (t_out_word)
//  cfg     | in  | APB psel/penable   | search_seed at address 0
// Add of n storage blocks places n+1 blocks, the index block first; each bitmap RAM
// probe passes through S_SCAN and S_SCAN_TST, up to NumBlocks probes per block.
// Seek answers in S_SEEK_RD; delete frees blocks in S_DEL_RD/S_DEL_FREE, then S_DEL_IDX.
// One request in flight; o_ready is high only when idle with no word pending.
// Reset starts a clearing pass over the bitmap and file-flag RAMs, o_ready low.
// A stalled output holds the sequencer until the word is taken.
module indexed_block_allocator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  iba_pkg::t_in_word      i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output iba_pkg::t_out_word     o_word,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import iba_pkg::*;

    t_state r_state, n_state;
    t_in_word r_req, n_req;
    logic [5:0] r_seed, r_lfsr, n_lfsr;
    logic [CntW-1:0] r_used, n_used;
    logic [PosW-1:0] r_start, n_start, r_off, n_off;
    logic [6:0] r_cnt, n_cnt;
    logic r_ov, n_ov;
    t_out_word r_ow, n_ow;
    logic [PosW-1:0] r_ipos, n_ipos;
    logic [6:0] r_len, n_len;
    logic [ClrW-1:0] r_clr, n_clr;

    logic [FidW-1:0] fid;
    logic fid_ok;
    logic [PosW-1:0] ip_rd;
    logic [7:0] fl_rd;
    logic f_pres;
    logic [6:0] len_rd;
    logic [5:0] bl_rd;
    logic ip_we, len_we, bl_we, bm_we;
    logic [FidW-1:0] len_waddr;
    logic [7:0] len_wdata;
    logic [PosW-1:0] bm_waddr;
    logic bm_wdata;
    logic bm_rd;
    logic [ListAw-1:0] bl_waddr, bl_raddr;
    logic [5:0] bl_wdata;
    logic [PosW-1:0] scan_p;
    logic cfg_wr;

    assign fid = r_req.file_id[FidW-1:0];
    assign fid_ok = {1'b0, r_req.file_id} < 7'(NumFileIds);
    assign f_pres = fl_rd[7];
    assign len_rd = fl_rd[6:0];
    assign scan_p = r_start + r_off;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'(REG_SEED));
    assign pready = 1'b1;
    assign prdata = (paddr == 2'(REG_SEED)) ? {26'd0, r_seed} : 32'd0;
    assign o_valid = r_ov;
    assign o_word = r_ow;
    assign o_ready = (r_state == S_IDLE) && !r_ov;

    iba_ram #(.Aw(FidW), .Dw(PosW)) u_ipos (
        .i_clk(i_clk), .i_we(ip_we), .i_waddr(fid), .i_wdata(r_ipos),
        .i_raddr(fid), .o_rdata(ip_rd));
    iba_ram #(.Aw(FidW), .Dw(8)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_raddr(fid), .o_rdata(fl_rd));
    iba_ram #(.Aw(ListAw), .Dw(6)) u_list (
        .i_clk(i_clk), .i_we(bl_we), .i_waddr(bl_waddr), .i_wdata(bl_wdata),
        .i_raddr(bl_raddr), .o_rdata(bl_rd));
    iba_ram #(.Aw(PosW), .Dw(1)) u_bmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(scan_p), .o_rdata(bm_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_seed  <= 6'd1;
            r_lfsr  <= 6'd1;
            r_used  <= '0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ov    <= n_ov;
            r_clr   <= n_clr;
            if (cfg_wr) begin
                r_seed <= pwdata[5:0];
                r_lfsr <= pwdata[5:0];
            end else begin
                r_lfsr <= n_lfsr;
            end
        end
        r_req <= n_req; r_start <= n_start; r_off <= n_off; r_cnt <= n_cnt;
        r_ow <= n_ow; r_ipos <= n_ipos; r_len <= n_len;
    end

    function automatic t_out_word mk(input logic [2:0] st, input logic [5:0] p,
                                     input logic k, input logic l,
                                     input logic [CntW-1:0] used);
        t_out_word w;
        w.status = st; w.block_pos = p; w.block_kind = k; w.last = l;
        w.free_blocks = 7'(CntW'(NumBlocks) - used);
        mk = w;
    endfunction

    always_comb begin
        n_state = r_state; n_req = r_req; n_lfsr = r_lfsr; n_used = r_used;
        n_start = r_start; n_off = r_off; n_clr = r_clr;
        n_cnt = r_cnt; n_ov = r_ov; n_ow = r_ow; n_ipos = r_ipos; n_len = r_len;
        ip_we = 1'b0; len_we = 1'b0; bl_we = 1'b0; bm_we = 1'b0;
        len_waddr = fid;
        len_wdata = {1'b1, r_req.size_blocks};
        bm_waddr = scan_p;
        bm_wdata = 1'b0;
        bl_waddr = {fid, r_cnt[5:0] - 6'd1};
        bl_wdata = 6'(scan_p);
        bl_raddr = {fid, r_req.block_index};
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            S_CLEAR: begin
                bm_we = 1'b1; bm_waddr = PosW'(r_clr);
                len_we = 1'b1; len_waddr = FidW'(r_clr); len_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_req = i_word;
                    n_state = (i_word.op == 2'd3) ? S_IDLE : S_META;
                end
            end
            S_META: n_state = S_DECIDE;
            S_DECIDE: begin
                n_cnt = '0;
                case (r_req.op)
                    OP_ADD: begin
                        if (!fid_ok) begin
                            n_ow = mk(ST_NO_SPACE, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else if (f_pres) begin
                            n_ow = mk(ST_EXISTS, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else if (r_req.size_blocks >= 7'd64 ||
                                     {1'b0, r_req.size_blocks} + 8'd1 >
                                     8'(CntW'(NumBlocks) - r_used)) begin
                            n_ow = mk(ST_NO_SPACE, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else begin
                            len_we = 1'b1;
                            n_start = PosW'(r_lfsr); n_lfsr = lfsr_next(r_lfsr);
                            n_off = '0; n_state = S_SCAN;
                        end
                    end
                    OP_SEEK: begin
                        if (!fid_ok || !f_pres) begin
                            n_ow = mk(ST_NO_FILE, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else if ({1'b0, r_req.block_index} >= len_rd) begin
                            n_ow = mk(ST_NO_BLOCK, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_state = S_SEEK_RD;
                        end
                    end
                    OP_DEL: begin
                        if (!fid_ok || !f_pres) begin
                            n_ow = mk(ST_NO_FILE, 6'd0, 1'b0, 1'b1, r_used);
                            n_ov = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_len = len_rd; n_ipos = ip_rd;
                            n_state = (len_rd == 7'd0) ? S_DEL_IDX : S_DEL_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (!r_ov) n_state = S_SCAN_TST;
            end
            S_SCAN_TST: begin
                if (!bm_rd) begin
                    bm_we = 1'b1; bm_wdata = 1'b1; n_used = r_used + 1'b1;
                    if (r_cnt == 7'd0) begin
                        n_ipos = scan_p; ip_we = 1'b0;
                    end else begin
                        bl_we = 1'b1;
                    end
                    n_ow = mk(ST_OK, 6'(scan_p), r_cnt != 7'd0,
                              r_cnt == r_req.size_blocks, r_used + 1'b1);
                    n_state = S_SCAN_CHK;
                end else begin
                    n_off = r_off + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN_CHK: begin
                ip_we = (r_cnt == 7'd0);
                if (!r_ov) begin
                    n_ov = 1'b1;
                    if (r_cnt == r_req.size_blocks) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                        n_start = PosW'(r_lfsr); n_lfsr = lfsr_next(r_lfsr);
                        n_off = '0; n_state = S_SCAN;
                    end
                end
            end
            S_SEEK_RD: begin
                n_ow = mk(ST_OK, bl_rd, 1'b1, 1'b1, r_used);
                n_ov = 1'b1; n_state = S_IDLE;
            end
            S_DEL_RD: begin
                bl_raddr = {fid, r_cnt[5:0]};
                n_state = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                bm_we = 1'b1; bm_waddr = PosW'(bl_rd);
                n_used = r_used - 1'b1;
                n_cnt = r_cnt + 7'd1;
                n_state = (r_cnt + 7'd1 == r_len) ? S_DEL_IDX : S_DEL_RD;
            end
            S_DEL_IDX: begin
                bm_we = 1'b1; bm_waddr = r_ipos;
                n_used = r_used - 1'b1;
                len_we = 1'b1; len_wdata = '0;
                n_ow = mk(ST_OK, 6'(r_ipos), 1'b0, 1'b1, r_used - 1'b1);
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/iba_checker.sv
// Checker: port-level properties of the indexed block allocator.
module iba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input iba_pkg::t_out_word o_word
);
    import iba_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word)) else $error("out hold");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.free_blocks <= 7'(NumBlocks)) else $error("free range");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != ST_OK |-> o_word.last && o_word.block_pos == 6'd0)
        else $error("error word");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while word pending");
endmodule

bind indexed_block_allocator iba_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word));
